FILE: sv/assert_macros.svh
// Assertion macros used by the checker file tcw_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TCW_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define TCW_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

FILE: sv/tcw_pkg.sv
// Shared constants, types and helpers of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W      = $clog2(CELLS);
    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = CHAR_W + ATTR_W;
    localparam int CURSOR_W    = 11;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_ERROR   = 8'd69;

    localparam logic [MODE_W-1:0] MODE_PRINT_CURSOR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRINT_POS    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR        = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ         = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_ATTR = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_ATTR   = 8'd1;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;
    localparam logic [ATTR_W-1:0] ERROR_ATTR_RESET   = 8'd244;

    typedef enum logic [2:0] {
        CMD_PRINT,
        CMD_MARK_ERROR,
        CMD_CLEAR,
        CMD_READ,
        CMD_READ_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               at_cursor;
        logic               newline;
        logic [CHAR_W-1:0]  char_code;
        logic [ATTR_W-1:0]  attribute;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
    } cmd_t;

    typedef struct packed {
        logic [ATTR_W-1:0] default_attr;
        logic [ATTR_W-1:0] error_attr;
    } cfg_t;

    function automatic logic [ADDR_W-1:0] cell_of(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

FILE: sv/tcw_front.sv
// Front end: accept items, classify them into commands, hand them to the queue.
`default_nettype none

module tcw_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [tcw_pkg::MODE_W-1:0]      s_mode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      s_char_code,
    input  wire logic [tcw_pkg::ATTR_W-1:0]      s_attribute,
    input  wire logic [tcw_pkg::COL_W-1:0]       s_column,
    input  wire logic [tcw_pkg::ROW_W-1:0]       s_row_index,
    input  wire tcw_pkg::cfg_t                   cfg,
    input  wire logic                            init_done,
    input  wire logic                            q_in_ready,
    output logic                                 push,
    output tcw_pkg::cmd_t                        push_cmd
);

    logic          cmd_valid_reg;
    tcw_pkg::cmd_t cmd_reg;
    tcw_pkg::cmd_t cmd_next;
    logic          in_range;

    assign in_range = (s_column < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
                      (s_row_index < tcw_pkg::ROW_W'(tcw_pkg::ROWS));

    always_comb begin
        cmd_next.at_cursor = 1'b0;
        cmd_next.newline   = (s_char_code == tcw_pkg::CH_NEWLINE);
        cmd_next.char_code = s_char_code;
        cmd_next.attribute = (s_attribute == '0) ? cfg.default_attr : s_attribute;
        cmd_next.column    = s_column;
        cmd_next.row       = s_row_index;
        unique case (s_mode)
            tcw_pkg::MODE_PRINT_CURSOR: begin
                cmd_next.kind      = tcw_pkg::CMD_PRINT;
                cmd_next.at_cursor = 1'b1;
            end
            tcw_pkg::MODE_PRINT_POS: begin
                cmd_next.kind = in_range ? tcw_pkg::CMD_PRINT : tcw_pkg::CMD_MARK_ERROR;
            end
            tcw_pkg::MODE_CLEAR: begin
                cmd_next.kind = tcw_pkg::CMD_CLEAR;
            end
            tcw_pkg::MODE_READ: begin
                cmd_next.kind = in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_READ_ERROR;
            end
        endcase
    end

    assign push     = cmd_valid_reg && q_in_ready;
    assign push_cmd = cmd_reg;
    assign s_ready  = init_done && (!cmd_valid_reg || q_in_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            cmd_valid_reg <= 1'b1;
        end else if (push) begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcw_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module tcw_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire tcw_pkg::cmd_t push_cmd,
    output logic               in_ready,
    input  wire logic          pop,
    output logic               out_valid,
    output tcw_pkg::cmd_t      out_cmd
);

    tcw_pkg::cmd_t                entries [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tcw_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [tcw_pkg::QCNT_W-1:0]   count_reg;
    logic [tcw_pkg::QCNT_W-1:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    function automatic logic [tcw_pkg::QPTR_W-1:0] ptr_inc(
        input logic [tcw_pkg::QPTR_W-1:0] p);
        return (p == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                : p + 1'b1;
    endfunction

    assign in_ready  = (count_reg != tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entries[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcw_back.sv
// Back end: cell buffer, cursor, scroll and fill sequencer, result register.
`default_nettype none

module tcw_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            head_valid,
    input  wire tcw_pkg::cmd_t                   head_cmd,
    output logic                                 pop,
    input  wire tcw_pkg::cfg_t                   cfg,
    output logic                                 init_done,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [tcw_pkg::CURSOR_W-1:0]         m_cursor_cell,
    output logic [tcw_pkg::CHAR_W-1:0]           m_read_char,
    output logic [tcw_pkg::ATTR_W-1:0]           m_read_attribute,
    output logic                                 m_scrolled,
    output logic                                 m_position_error
);

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_SCROLL,
        ST_DONE
    } state_t;

    localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL =
        tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
    localparam logic [tcw_pkg::ADDR_W-1:0] LAST_ROW_BASE =
        tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);

    logic [tcw_pkg::CELL_W-1:0]   mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0]   rd_data_reg;

    state_t                       state_reg;
    logic [tcw_pkg::ADDR_W-1:0]   cnt_reg;
    logic                         init_reg;
    logic [tcw_pkg::CELL_W-1:0]   fill_data_reg;
    logic                         pend_reg;
    logic [tcw_pkg::ADDR_W-1:0]   pend_addr_reg;
    logic                         pend_zero_reg;
    logic [tcw_pkg::ROW_W-1:0]    cur_row_reg;
    logic [tcw_pkg::COL_W-1:0]    cur_col_reg;
    logic                         res_scrolled_reg;
    logic                         res_perr_reg;
    logic                         res_read_reg;

    logic                         m_valid_reg;
    logic [tcw_pkg::CURSOR_W-1:0] cursor_cell_reg;
    logic [tcw_pkg::CHAR_W-1:0]   read_char_reg;
    logic [tcw_pkg::ATTR_W-1:0]   read_attr_reg;
    logic                         scrolled_reg;
    logic                         perr_reg;

    logic                         out_free;
    logic [tcw_pkg::ROW_W-1:0]    pos_row;
    logic [tcw_pkg::COL_W-1:0]    pos_col;
    logic                         wrap;
    logic                         do_scroll;
    logic [tcw_pkg::ROW_W-1:0]    next_row;
    logic [tcw_pkg::COL_W-1:0]    next_col;
    logic [tcw_pkg::ADDR_W-1:0]   cur_cell;

    logic                         mem_we;
    logic [tcw_pkg::ADDR_W-1:0]   mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
    logic                         mem_re;
    logic [tcw_pkg::ADDR_W-1:0]   mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]   pend_data;

    assign out_free  = !m_valid_reg || m_ready;
    assign pop       = (state_reg == ST_IDLE) && head_valid && out_free;
    assign init_done = !init_reg;

    // Cell that a print lands on, and where the cursor goes after it.
    assign pos_row   = head_cmd.at_cursor ? cur_row_reg : head_cmd.row;
    assign pos_col   = head_cmd.at_cursor ? cur_col_reg : head_cmd.column;
    assign wrap      = head_cmd.newline ||
                       (pos_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    assign do_scroll = wrap && (pos_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign next_row  = wrap ? pos_row + 1'b1 : pos_row;
    assign next_col  = wrap ? '0 : pos_col + 1'b1;
    assign cur_cell  = tcw_pkg::cell_of(cur_row_reg, cur_col_reg);
    assign pend_data = pend_zero_reg ? '0 : rd_data_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = fill_data_reg;
        mem_re    = 1'b0;
        mem_raddr = tcw_pkg::cell_of(head_cmd.row, head_cmd.column);
        unique case (state_reg)
            ST_FILL: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                if (pop) begin
                    if (head_cmd.kind == tcw_pkg::CMD_PRINT && !head_cmd.newline) begin
                        mem_we    = 1'b1;
                        mem_waddr = tcw_pkg::cell_of(pos_row, pos_col);
                        mem_wdata = {head_cmd.attribute, head_cmd.char_code};
                    end else if (head_cmd.kind == tcw_pkg::CMD_MARK_ERROR) begin
                        mem_we    = 1'b1;
                        mem_waddr = LAST_CELL;
                        mem_wdata = {cfg.error_attr, tcw_pkg::CH_ERROR};
                    end else if (head_cmd.kind == tcw_pkg::CMD_READ) begin
                        mem_re = 1'b1;
                    end
                end
            end
            ST_SCROLL: begin
                // Read a row below, write it in the next cycle one row up.
                mem_re    = (cnt_reg < LAST_ROW_BASE);
                mem_raddr = cnt_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                mem_we    = pend_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = pend_data;
            end
            ST_DONE: begin
                mem_we    = pend_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = pend_data;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_FILL;
            cnt_reg          <= '0;
            init_reg         <= 1'b1;
            fill_data_reg    <= '0;
            pend_reg         <= 1'b0;
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_FILL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_CELL) begin
                        init_reg  <= 1'b0;
                        state_reg <= init_reg ? ST_IDLE : ST_DONE;
                    end
                end
                ST_IDLE: begin
                    if (pop) begin
                        res_scrolled_reg <= (head_cmd.kind == tcw_pkg::CMD_PRINT) && do_scroll;
                        res_perr_reg     <= (head_cmd.kind == tcw_pkg::CMD_MARK_ERROR) ||
                                            (head_cmd.kind == tcw_pkg::CMD_READ_ERROR);
                        res_read_reg     <= (head_cmd.kind == tcw_pkg::CMD_READ);
                        cnt_reg          <= '0;
                        unique case (head_cmd.kind)
                            tcw_pkg::CMD_PRINT: begin
                                if (do_scroll) begin
                                    cur_row_reg <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                                    cur_col_reg <= '0;
                                    state_reg   <= ST_SCROLL;
                                end else begin
                                    cur_row_reg <= next_row;
                                    cur_col_reg <= next_col;
                                    state_reg   <= ST_DONE;
                                end
                            end
                            tcw_pkg::CMD_CLEAR: begin
                                fill_data_reg <= {cfg.default_attr, tcw_pkg::CH_SPACE};
                                state_reg     <= ST_FILL;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCROLL: begin
                    pend_reg      <= 1'b1;
                    pend_addr_reg <= cnt_reg;
                    pend_zero_reg <= (cnt_reg >= LAST_ROW_BASE);
                    cnt_reg       <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_CELL) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    pend_reg        <= 1'b0;
                    m_valid_reg     <= 1'b1;
                    cursor_cell_reg <= tcw_pkg::CURSOR_W'(cur_cell);
                    read_char_reg   <= res_read_reg ? rd_data_reg[tcw_pkg::CHAR_W-1:0]
                                                    : '0;
                    read_attr_reg   <= res_read_reg ?
                                       rd_data_reg[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
                    scrolled_reg    <= res_scrolled_reg;
                    perr_reg        <= res_perr_reg;
                    state_reg       <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_cursor_cell    = cursor_cell_reg;
    assign m_read_char      = read_char_reg;
    assign m_read_attribute = read_attr_reg;
    assign m_scrolled       = scrolled_reg;
    assign m_position_error = perr_reg;

endmodule

`default_nettype wire

FILE: sv/text_console_writer.sv
// Top level: character-cell text console with cursor, scrolling and clear.
// An item passes the front-end register and the queue, then the back end's execute and result steps.
// The back end takes a new item only after the result step of the last one and once the result register is free.
// Scroll or clear: one buffer cell per cycle on one write port.
// Reset: synchronous, active low; a zero fill of all CELLS cells follows with s_ready
// low; configuration writes are taken throughout.
`default_nettype none

module text_console_writer (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // Configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]          cfg_data,

    // Input item channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [tcw_pkg::MODE_W-1:0]          s_mode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]          s_char_code,
    input  wire logic [tcw_pkg::ATTR_W-1:0]          s_attribute,
    input  wire logic [tcw_pkg::COL_W-1:0]           s_column,
    input  wire logic [tcw_pkg::ROW_W-1:0]           s_row_index,

    // Result item channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [tcw_pkg::CURSOR_W-1:0]             m_cursor_cell,
    output logic [tcw_pkg::CHAR_W-1:0]               m_read_char,
    output logic [tcw_pkg::ATTR_W-1:0]               m_read_attribute,
    output logic                                     m_scrolled,
    output logic                                     m_position_error
);

    // Configuration registers; unknown indexes are dropped.
    tcw_pkg::cfg_t cfg_reg;

    logic          init_done;
    logic          q_in_ready;
    logic          push;
    tcw_pkg::cmd_t push_cmd;
    logic          head_valid;
    tcw_pkg::cmd_t head_cmd;
    logic          pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.default_attr <= tcw_pkg::DEFAULT_ATTR_RESET;
            cfg_reg.error_attr   <= tcw_pkg::ERROR_ATTR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == tcw_pkg::CFG_DEFAULT_ATTR) begin
                cfg_reg.default_attr <= cfg_data;
            end else if (cfg_index == tcw_pkg::CFG_ERROR_ATTR) begin
                cfg_reg.error_attr <= cfg_data;
            end
        end
    end

    // Front end: take the item, check the position, resolve the attribute.
    tcw_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_char_code (s_char_code),
        .s_attribute (s_attribute),
        .s_column    (s_column),
        .s_row_index (s_row_index),
        .cfg         (cfg_reg),
        .init_done   (init_done),
        .q_in_ready  (q_in_ready),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Queue: lets the front end keep taking items while the back end scrolls.
    tcw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .in_ready  (q_in_ready),
        .pop       (pop),
        .out_valid (head_valid),
        .out_cmd   (head_cmd)
    );

    // Back end: owns the cell buffer and the cursor, produces results.
    tcw_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (head_valid),
        .head_cmd         (head_cmd),
        .pop              (pop),
        .cfg              (cfg_reg),
        .init_done        (init_done),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_cell    (m_cursor_cell),
        .m_read_char      (m_read_char),
        .m_read_attribute (m_read_attribute),
        .m_scrolled       (m_scrolled),
        .m_position_error (m_position_error)
    );

endmodule

`default_nettype wire

FILE: sv/tcw_checker.sv
// Port-level checks of the text console writer result channel.
`default_nettype none
`include "assert_macros.svh"

module tcw_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [tcw_pkg::CURSOR_W-1:0]     m_cursor_cell,
    input wire logic [tcw_pkg::CHAR_W-1:0]       m_read_char,
    input wire logic [tcw_pkg::ATTR_W-1:0]       m_read_attribute,
    input wire logic                             m_scrolled,
    input wire logic                             m_position_error
);

    `TCW_ASSERT_ALWAYS(a_no_result_after_reset, aclk, !aresetn |=> !m_valid, "result after reset")

    `TCW_ASSERT(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_cursor_cell) && $stable(m_read_char), "stalled result changed")

    `TCW_ASSERT(a_cursor_range, aclk, aresetn, m_valid |-> m_cursor_cell < tcw_pkg::CURSOR_W'(tcw_pkg::CELLS), "cursor outside buffer")

    `TCW_ASSERT(a_scroll_cursor, aclk, aresetn, m_valid && m_scrolled |-> m_cursor_cell == tcw_pkg::CURSOR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS) && !m_position_error, "scroll left cursor off last row start")

    `TCW_ASSERT(a_error_no_data, aclk, aresetn, m_valid && m_position_error |-> m_read_char == '0 && m_read_attribute == '0, "error result carries cell data")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_cursor_cell    (m_cursor_cell),
    .m_read_char      (m_read_char),
    .m_read_attribute (m_read_attribute),
    .m_scrolled       (m_scrolled),
    .m_position_error (m_position_error)
);

`default_nettype wire
